### design/lre_pkg.sv
// Shared request codes, widths and state types for the linked list reorder engine.
`timescale 1ns / 1ps

package lre_pkg;

   localparam int ITEM_W = 11;
   localparam int TYPE_W = 3;
   localparam int SUM_W  = 20;
   localparam int CFG_W  = 11;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   // Word index of the list length register on the configuration port.
   localparam logic REG_LIST_LENGTH = 1'b0;

   localparam logic [TYPE_W-1:0] REQ_INIT    = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_LEFT    = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_RIGHT   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_SWAP    = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_REVERSE = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_REPORT  = 3'd5;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INIT = 7'b0000010,
      ST_RPT  = 7'b0000100,
      ST_RDX  = 7'b0001000,
      ST_RDY  = 7'b0010000,
      ST_EVAL = 7'b0100000,
      ST_JOIN = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      JK_LEFT,
      JK_RIGHT,
      JK_SWAP_NEAR,
      JK_SWAP_FAR
   } join_kind_type;

endpackage

### design/linked_list_reorder_engine.sv
// Top level of the linked list reorder engine: link tables, sequencer and register port.
`timescale 1ns / 1ps

// Holds a circular doubly linked order of items 1..n in two link RAMs with node 0 as the
// head sentinel, plus a lazy reversal flag. An item is taken when start is high and busy
// is low. Reverse and ignored requests never raise busy. Init writes one link entry per
// cycle, entries 0 through n, and keeps busy high meanwhile. Move and swap requests read
// the x and y entries, decide, and then write one join per cycle: none when nothing moves,
// three for a move or an adjacent swap, four for any other swap. A report follows one
// link per cycle through the next table, and its result appears on rsp_strobe in the same
// cycle busy falls (for an empty list, in the cycle after the item, busy never raised).
// The receiver cannot stall, so each result is shown for one cycle only. The link RAMs
// need no clearing after reset.
module linked_list_reorder_engine #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lre_pkg::TYPE_W-1:0]          req_type,
   input  logic [lre_pkg::ITEM_W-1:0]          req_item_x,
   input  logic [lre_pkg::ITEM_W-1:0]          req_item_y,
   output logic                                rsp_strobe,
   output logic [lre_pkg::SUM_W-1:0]           rsp_odd_position_sum,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lre_pkg::ADDR_W-1:0]          paddr,
   input  logic [lre_pkg::DATA_W-1:0]          pwdata,
   output logic [lre_pkg::DATA_W-1:0]          prdata,
   output logic                                pready
);

   localparam int LINK_W = $clog2(MAX_ITEMS + 1);
   localparam int CMP_W  = (LINK_W > lre_pkg::ITEM_W) ? LINK_W : lre_pkg::ITEM_W;

   lre_pkg::state_type     state_ff, state_in;
   lre_pkg::join_kind_type kind_ff, kind_in;

   logic [lre_pkg::CFG_W-1:0] list_length_ff, list_length_in;
   logic                      reversed_ff, reversed_in;
   logic [LINK_W-1:0]         active_len_ff, active_len_in;
   logic [LINK_W-1:0]         cnt_ff, cnt_in;
   logic [1:0]                step_ff, step_in;
   logic [LINK_W-1:0]         x_ff, x_in, y_ff, y_in;
   logic [LINK_W-1:0]         lx_ff, lx_in, rx_ff, rx_in, ly_ff, ly_in, ry_ff, ry_in;
   logic [lre_pkg::SUM_W-1:0] odd_sum_ff, odd_sum_in, even_sum_ff, even_sum_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [lre_pkg::SUM_W-1:0] rsp_sum_ff, rsp_sum_in;

   // Link RAMs with registered read data.
   logic [LINK_W-1:0] next_mem [0:MAX_ITEMS];
   logic [LINK_W-1:0] prev_mem [0:MAX_ITEMS];
   logic [LINK_W-1:0] rd_next_ff, rd_prev_ff;
   logic [LINK_W-1:0] rd_addr;
   logic              wr_en;
   logic [LINK_W-1:0] next_wa, next_wd, prev_wa, prev_wd;
   logic [LINK_W-1:0] join_a, join_b;
   logic              join_last;

   logic              accept, cfg_write;
   logic [CMP_W-1:0]  cfg_len_ext, x_ext, y_ext, len_ext;
   logic              items_ok;
   logic [LINK_W-1:0] init_len;
   logic [lre_pkg::SUM_W-1:0] cur_ext, odd_fin, even_fin;

   assign accept    = start && !busy;
   assign busy      = (state_ff != lre_pkg::ST_IDLE);
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == lre_pkg::REG_LIST_LENGTH)
                      ? {{(lre_pkg::DATA_W - lre_pkg::CFG_W){1'b0}}, list_length_ff}
                      : '0;

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_odd_position_sum = rsp_sum_ff;

   assign cfg_len_ext = CMP_W'(list_length_ff);
   assign init_len    = (cfg_len_ext > CMP_W'(MAX_ITEMS)) ? LINK_W'(MAX_ITEMS)
                                                           : cfg_len_ext[LINK_W-1:0];
   assign x_ext    = CMP_W'(req_item_x);
   assign y_ext    = CMP_W'(req_item_y);
   assign len_ext  = CMP_W'(active_len_ff);
   assign items_ok = (x_ext != y_ext) && (x_ext != '0) && (y_ext != '0)
                     && (x_ext <= len_ext) && (y_ext <= len_ext);

   // Report accumulation for the item now held in the next-table read register.
   assign cur_ext  = lre_pkg::SUM_W'(rd_next_ff);
   assign odd_fin  = cnt_ff[0] ? odd_sum_ff + cur_ext : odd_sum_ff;
   assign even_fin = cnt_ff[0] ? even_sum_ff : even_sum_ff + cur_ext;

   always_comb begin
      priority case (1'b1)
         state_ff == lre_pkg::ST_RDX: rd_addr = x_ff;
         state_ff == lre_pkg::ST_RDY: rd_addr = y_ff;
         state_ff == lre_pkg::ST_RPT: rd_addr = rd_next_ff;
         default:                     rd_addr = '0;
      endcase
   end

   // Join sequences, one join per step; a join (a, b) links a forward to b.
   always_comb begin
      join_a    = lx_ff;
      join_b    = rx_ff;
      join_last = 1'b0;
      unique case (kind_ff)
         lre_pkg::JK_LEFT: begin
            unique case (step_ff)
               2'd0:    begin join_a = lx_ff; join_b = rx_ff; end
               2'd1:    begin join_a = ly_ff; join_b = x_ff; end
               default: begin join_a = x_ff;  join_b = y_ff;  join_last = 1'b1; end
            endcase
         end
         lre_pkg::JK_RIGHT: begin
            unique case (step_ff)
               2'd0:    begin join_a = lx_ff; join_b = rx_ff; end
               2'd1:    begin join_a = x_ff;  join_b = ry_ff; end
               default: begin join_a = y_ff;  join_b = x_ff;  join_last = 1'b1; end
            endcase
         end
         lre_pkg::JK_SWAP_NEAR: begin
            unique case (step_ff)
               2'd0:    begin join_a = lx_ff; join_b = y_ff; end
               2'd1:    begin join_a = y_ff;  join_b = x_ff; end
               default: begin join_a = x_ff;  join_b = ry_ff; join_last = 1'b1; end
            endcase
         end
         default: begin
            unique case (step_ff)
               2'd0:    begin join_a = lx_ff; join_b = y_ff; end
               2'd1:    begin join_a = y_ff;  join_b = rx_ff; end
               2'd2:    begin join_a = ly_ff; join_b = x_ff; end
               default: begin join_a = x_ff;  join_b = ry_ff; join_last = 1'b1; end
            endcase
         end
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      next_wa = join_a;
      next_wd = join_b;
      prev_wa = join_b;
      prev_wd = join_a;
      if (state_ff == lre_pkg::ST_INIT) begin
         wr_en   = 1'b1;
         next_wa = cnt_ff;
         next_wd = (cnt_ff == active_len_ff) ? '0 : cnt_ff + LINK_W'(1);
         prev_wa = cnt_ff;
         prev_wd = (cnt_ff == '0) ? active_len_ff : cnt_ff - LINK_W'(1);
      end else if (state_ff == lre_pkg::ST_JOIN) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         next_mem[next_wa] <= next_wd;
         prev_mem[prev_wa] <= prev_wd;
      end
      rd_next_ff <= next_mem[rd_addr];
      rd_prev_ff <= prev_mem[rd_addr];
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      list_length_in = list_length_ff;
      reversed_in    = reversed_ff;
      active_len_in  = active_len_ff;
      cnt_in         = cnt_ff;
      step_in        = step_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      lx_in          = lx_ff;
      rx_in          = rx_ff;
      ly_in          = ly_ff;
      ry_in          = ry_ff;
      odd_sum_in     = odd_sum_ff;
      even_sum_in    = even_sum_ff;
      rsp_strobe_in  = 1'b0;
      rsp_sum_in     = rsp_sum_ff;

      if (cfg_write && paddr[2] == lre_pkg::REG_LIST_LENGTH) begin
         list_length_in = pwdata[lre_pkg::CFG_W-1:0];
      end

      unique case (state_ff)
         lre_pkg::ST_IDLE: begin
            if (accept) begin
               x_in    = x_ext[LINK_W-1:0];
               y_in    = y_ext[LINK_W-1:0];
               step_in = 2'd0;
               priority if (req_type == lre_pkg::REQ_INIT) begin
                  active_len_in = init_len;
                  reversed_in   = 1'b0;
                  cnt_in        = '0;
                  state_in      = lre_pkg::ST_INIT;
               end else if (req_type == lre_pkg::REQ_REVERSE) begin
                  reversed_in = !reversed_ff;
               end else if (req_type == lre_pkg::REQ_REPORT) begin
                  odd_sum_in  = '0;
                  even_sum_in = '0;
                  cnt_in      = LINK_W'(1);
                  if (active_len_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_sum_in    = '0;
                  end else begin
                     state_in = lre_pkg::ST_RPT;
                  end
               end else if ((req_type == lre_pkg::REQ_LEFT || req_type == lre_pkg::REQ_RIGHT
                             || req_type == lre_pkg::REQ_SWAP) && items_ok) begin
                  // While reversed, a move to the left becomes a move to the right.
                  if (req_type == lre_pkg::REQ_SWAP) begin
                     kind_in = lre_pkg::JK_SWAP_FAR;
                  end else if ((req_type == lre_pkg::REQ_LEFT) != reversed_ff) begin
                     kind_in = lre_pkg::JK_LEFT;
                  end else begin
                     kind_in = lre_pkg::JK_RIGHT;
                  end
                  state_in = lre_pkg::ST_RDX;
               end else begin
                  state_in = lre_pkg::ST_IDLE;
               end
            end
         end
         lre_pkg::ST_INIT: begin
            cnt_in = cnt_ff + LINK_W'(1);
            if (cnt_ff == active_len_ff) begin
               state_in = lre_pkg::ST_IDLE;
            end
         end
         lre_pkg::ST_RPT: begin
            odd_sum_in  = odd_fin;
            even_sum_in = even_fin;
            cnt_in      = cnt_ff + LINK_W'(1);
            if (cnt_ff == active_len_ff) begin
               // With the flag set and n even, the odd positions of the reversed order are
               // the even positions of the stored order.
               rsp_strobe_in = 1'b1;
               rsp_sum_in    = (reversed_ff && !active_len_ff[0]) ? even_fin : odd_fin;
               state_in      = lre_pkg::ST_IDLE;
            end
         end
         lre_pkg::ST_RDX: begin
            state_in = lre_pkg::ST_RDY;
         end
         lre_pkg::ST_RDY: begin
            lx_in    = rd_prev_ff;
            rx_in    = rd_next_ff;
            state_in = lre_pkg::ST_EVAL;
         end
         lre_pkg::ST_EVAL: begin
            ly_in    = rd_prev_ff;
            ry_in    = rd_next_ff;
            state_in = lre_pkg::ST_JOIN;
            unique case (kind_ff)
               lre_pkg::JK_LEFT: begin
                  if (rd_prev_ff == x_ff) state_in = lre_pkg::ST_IDLE;
               end
               lre_pkg::JK_RIGHT: begin
                  if (rd_next_ff == x_ff) state_in = lre_pkg::ST_IDLE;
               end
               default: begin
                  if (rd_next_ff == x_ff) begin
                     // y sits just before x: exchange the roles so x leads.
                     x_in    = y_ff;
                     y_in    = x_ff;
                     lx_in   = rd_prev_ff;
                     rx_in   = rd_next_ff;
                     ly_in   = lx_ff;
                     ry_in   = rx_ff;
                     kind_in = lre_pkg::JK_SWAP_NEAR;
                  end else if (rx_ff == y_ff) begin
                     kind_in = lre_pkg::JK_SWAP_NEAR;
                  end else begin
                     kind_in = lre_pkg::JK_SWAP_FAR;
                  end
               end
            endcase
         end
         lre_pkg::ST_JOIN: begin
            step_in = step_ff + 2'd1;
            if (join_last) begin
               state_in = lre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lre_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lre_pkg::ST_IDLE;
         list_length_ff <= lre_pkg::CFG_W'(1);
         reversed_ff    <= 1'b0;
         active_len_ff  <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         list_length_ff <= list_length_in;
         reversed_ff    <= reversed_in;
         active_len_ff  <= active_len_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      cnt_ff      <= cnt_in;
      step_ff     <= step_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      lx_ff       <= lx_in;
      rx_ff       <= rx_in;
      ly_ff       <= ly_in;
      ry_ff       <= ry_in;
      odd_sum_ff  <= odd_sum_in;
      even_sum_ff <= even_sum_in;
      rsp_sum_ff  <= rsp_sum_in;
   end

   // A result only follows the last report step or a report on an empty list.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff == lre_pkg::ST_RPT)
                      || $past(start && !busy && req_type == lre_pkg::REQ_REPORT)))
      else $error("result strobe without a finished report");

   // An init always occupies the engine while the tables are rebuilt.
   a_init_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == lre_pkg::REQ_INIT) |=> busy)
      else $error("init item did not raise busy");

   // The report walk never runs past the active list length.
   a_walk_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == lre_pkg::ST_RPT) |-> (cnt_ff <= active_len_ff && cnt_ff != '0))
      else $error("report walk out of range");

endmodule
